// File: rtl/pgalloc_pkg.sv
// Shared constants, codes and result struct for the page allocator.
package pgalloc_pkg;

  localparam int DefMaxIds    = 256;
  localparam int DefMaxBlocks = 16;
  localparam int DefMaxPpb    = 16;

  localparam logic [4:0] PpbReset = 5'd4;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_DOUBLE    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] new_id;
    logic [7:0] phys_slot;
    logic [4:0] blocks_reclaimed;
    logic [8:0] live_total;
    logic [8:0] free_total;
    logic [8:0] id_space_length;
  } res_t;

endpackage

// File: rtl/pgalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgalloc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/pgalloc_core.sv
// Command sequencer: id table, free stack, carve, trim and compaction walks.
module pgalloc_core
  import pgalloc_pkg::*;
#(
  parameter int MAX_IDS    = DefMaxIds,
  parameter int MAX_BLOCKS = DefMaxBlocks,
  parameter int MAX_PPB    = DefMaxPpb
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [7:0]                         page_id_i,
  input  logic                               hold_i,
  input  logic [$clog2(MAX_PPB+1)-1:0]       ppb_i,
  output logic                               blocks_nz_o,
  output logic                               res_valid_o,
  output res_t                               res_o
);

  localparam int Total = MAX_BLOCKS * MAX_PPB;
  localparam int IdW   = $clog2(MAX_IDS + 1);
  localparam int IdxW  = $clog2(MAX_IDS);
  localparam int DepW  = $clog2(Total + 1);
  localparam int SlotW = (Total > 1) ? $clog2(Total) : 1;
  localparam int BlkW  = $clog2(MAX_BLOCKS + 1);
  localparam int WideW = (IdW > DepW) ? IdW : DepW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CARVE  = 4'd1;
  localparam logic [3:0] S_POPRD  = 4'd2;
  localparam logic [3:0] S_POPWR  = 4'd3;
  localparam logic [3:0] S_FREERD = 4'd4;
  localparam logic [3:0] S_FREEWR = 4'd5;
  localparam logic [3:0] S_TRIM   = 4'd6;
  localparam logic [3:0] S_CWALK  = 4'd7;
  localparam logic [3:0] S_CKEEP  = 4'd8;
  localparam logic [3:0] S_CFILL  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [MAX_IDS-1:0] vld_q, vld_d;
  logic [IdW-1:0]     id_cnt_q, id_cnt_d, live_q, live_d;
  logic [DepW-1:0]    depth_q, depth_d;
  logic [BlkW-1:0]    blocks_q, blocks_d, k_q, k_d, recl_q, recl_d;
  logic [WideW-1:0]   ctr_q, ctr_d, rank_q, rank_d, acc_q, acc_d;
  logic [SlotW-1:0]   base_q, base_d, slot_q, slot_d;
  logic [IdxW-1:0]    pid_q, pid_d, nid_q, nid_d;
  logic [2:0]         status_q, status_d;

  logic             push_en;
  logic [SlotW-1:0] push_val;
  logic             map_we;
  logic [IdxW-1:0]  map_waddr, map_raddr;
  logic [SlotW-1:0] map_wdata, map_rdata;
  logic [SlotW-1:0] st_raddr, st_rdata;
  logic             accept;
  logic [IdxW-1:0]  pid_idx;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign pid_idx     = IdxW'(page_id_i);
  assign blocks_nz_o = (blocks_q != '0);

  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    id_cnt_d  = id_cnt_q;
    live_d    = live_q;
    depth_d   = depth_q;
    blocks_d  = blocks_q;
    k_d       = k_q;
    recl_d    = recl_q;
    ctr_d     = ctr_q;
    rank_d    = rank_q;
    acc_d     = acc_q;
    base_d    = base_q;
    slot_d    = slot_q;
    pid_d     = pid_q;
    nid_d     = nid_q;
    status_d  = status_q;
    push_en   = 1'b0;
    push_val  = '0;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_raddr = pid_q;
    st_raddr  = SlotW'(depth_q - DepW'(1));
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          nid_d    = '0;
          slot_d   = '0;
          recl_d   = '0;
          pid_d    = pid_idx;
          state_d  = S_DONE;
          unique case (cmd_i)
            CMD_ALLOC: begin
              if (32'(id_cnt_q) >= MAX_IDS) begin
                status_d = ST_FULL;
              end else if (depth_q == '0 && 32'(blocks_q) >= MAX_BLOCKS) begin
                status_d = ST_EXHAUSTED;
              end else if (depth_q == '0) begin
                base_d  = SlotW'(32'(blocks_q) * 32'(ppb_i));
                ctr_d   = '0;
                state_d = S_CARVE;
              end else begin
                state_d = S_POPRD;
              end
            end
            CMD_FREE: begin
              if (32'(page_id_i) >= 32'(id_cnt_q) || 32'(page_id_i) >= MAX_IDS) begin
                status_d = ST_RANGE;
              end else if (!vld_q[pid_idx]) begin
                status_d = ST_DOUBLE;
              end else begin
                vld_d[pid_idx] = 1'b0;
                live_d  = live_q - IdW'(1);
                state_d = S_FREERD;
              end
            end
            CMD_COMPACT: begin
              if (blocks_q != '0) begin
                ctr_d   = '0;
                rank_d  = '0;
                state_d = S_CWALK;
              end
            end
            default: begin
              recl_d   = blocks_q;
              vld_d    = '0;
              id_cnt_d = '0;
              live_d   = '0;
              depth_d  = '0;
              blocks_d = '0;
            end
          endcase
        end
      end
      S_CARVE: begin
        push_en  = 1'b1;
        push_val = base_q + SlotW'(ctr_q);
        ctr_d    = ctr_q + WideW'(1);
        if (ctr_q == WideW'(ppb_i) - WideW'(1)) begin
          blocks_d = blocks_q + BlkW'(1);
          state_d  = S_POPRD;
        end
      end
      S_POPRD: begin
        depth_d = depth_q - DepW'(1);
        state_d = S_POPWR;
      end
      S_POPWR: begin
        slot_d    = st_rdata;
        nid_d     = IdxW'(id_cnt_q);
        map_we    = 1'b1;
        map_waddr = IdxW'(id_cnt_q);
        map_wdata = st_rdata;
        vld_d[IdxW'(id_cnt_q)] = 1'b1;
        id_cnt_d  = id_cnt_q + IdW'(1);
        live_d    = live_q + IdW'(1);
        state_d   = S_DONE;
      end
      S_FREERD: state_d = S_FREEWR;
      S_FREEWR: begin
        push_en  = 1'b1;
        push_val = map_rdata;
        state_d  = S_TRIM;
      end
      S_TRIM: begin
        if (id_cnt_q != '0 && !vld_q[IdxW'(id_cnt_q - IdW'(1))]) begin
          id_cnt_d = id_cnt_q - IdW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_CWALK: begin
        if (ctr_q < WideW'(id_cnt_q)) begin
          if (vld_q[IdxW'(ctr_q)]) begin
            map_we    = 1'b1;
            map_waddr = IdxW'(ctr_q);
            map_wdata = SlotW'(rank_q);
            rank_d    = rank_q + WideW'(1);
          end
          ctr_d = ctr_q + WideW'(1);
        end else begin
          k_d     = '0;
          acc_d   = '0;
          state_d = S_CKEEP;
        end
      end
      S_CKEEP: begin
        if (acc_q < rank_q && k_q < blocks_q) begin
          acc_d = acc_q + WideW'(ppb_i);
          k_d   = k_q + BlkW'(1);
        end else begin
          recl_d   = blocks_q - k_q;
          blocks_d = k_q;
          depth_d  = '0;
          ctr_d    = rank_q;
          state_d  = S_CFILL;
        end
      end
      S_CFILL: begin
        if (ctr_q < acc_q) begin
          push_en  = 1'b1;
          push_val = SlotW'(ctr_q);
          ctr_d    = ctr_q + WideW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      // Result waits here until the output register can take it.
      S_DONE: begin
        if (!hold_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (push_en && 32'(depth_q) < Total) begin
      depth_d = depth_q + DepW'(1);
    end
  end

  pgalloc_ram #(.Width(SlotW), .Depth(MAX_IDS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  pgalloc_ram #(.Width(SlotW), .Depth(1 << SlotW)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push_en && 32'(depth_q) < Total),
    .waddr_i (SlotW'(depth_q)),
    .wdata_i (push_val),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      id_cnt_q <= '0;
      live_q   <= '0;
      depth_q  <= '0;
      blocks_q <= '0;
    end else begin
      state_q  <= state_d;
      vld_q    <= vld_d;
      id_cnt_q <= id_cnt_d;
      live_q   <= live_d;
      depth_q  <= depth_d;
      blocks_q <= blocks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    recl_q   <= recl_d;
    ctr_q    <= ctr_d;
    rank_q   <= rank_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    slot_q   <= slot_d;
    pid_q    <= pid_d;
    nid_q    <= nid_d;
    status_q <= status_d;
  end

  assign res_valid_o            = (state_q == S_DONE);
  assign res_o.status           = status_q;
  assign res_o.new_id           = 8'(nid_q);
  assign res_o.phys_slot        = 8'(slot_q);
  assign res_o.blocks_reclaimed = 5'(recl_q);
  assign res_o.live_total       = 9'(live_q);
  assign res_o.free_total       = 9'(depth_q);
  assign res_o.id_space_length  = 9'(id_cnt_q);

  a_live_le_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= id_cnt_q) else $error("live count above id table length");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !hold_i |=> state_q == S_IDLE) else $error("result state not left");
  a_blocks_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(blocks_q) <= MAX_BLOCKS) else $error("blocks held above pool size");
  a_pop_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POPWR |=> id_cnt_q == $past(id_cnt_q) + IdW'(1))
    else $error("grant did not extend id table");

endmodule

// File: rtl/page_allocator_with_compaction.sv
// Top level of the page allocator: config register, core and result register.
// One command at a time: the sequential core walks the id table and free
// stack through one write and one read port each, and takes a new command
// only after the last result has moved to the output register.
// Reset (async, active low) empties the table, stack and pool and sets
// pages_per_block to 4; no clearing pass is needed.
module page_allocator_with_compaction
  import pgalloc_pkg::*;
#(
  parameter int MAX_IDS    = DefMaxIds,
  parameter int MAX_BLOCKS = DefMaxBlocks,
  parameter int MAX_PPB    = DefMaxPpb
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] page_id
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] new_id, [15:8] phys_slot, [20:16] blocks_reclaimed,
  // [29:21] live_total, [38:30] free_total, [47:39] id_space_length
  output logic [47:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i        // pages_per_block
);

  localparam int PpbW = $clog2(MAX_PPB + 1);

  logic [4:0]      ppb_raw_q;
  logic [PpbW-1:0] ppb_eff;
  logic            blocks_nz;
  logic            res_valid;
  res_t            res, out_q;
  logic            out_valid_q;
  logic            out_free;

  // Geometry is locked while any block is carved.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppb_raw_q <= PpbReset;
    end else if (cfg_valid_i && !blocks_nz) begin
      ppb_raw_q <= cfg_data_i;
    end
  end

  // Zero acts as one, oversize clamps to the largest block.
  always_comb begin
    if (ppb_raw_q == '0) begin
      ppb_eff = PpbW'(1);
    end else if (32'(ppb_raw_q) > MAX_PPB) begin
      ppb_eff = PpbW'(MAX_PPB);
    end else begin
      ppb_eff = PpbW'(ppb_raw_q);
    end
  end

  // Output register can take a new word when empty or draining this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  pgalloc_core #(
    .MAX_IDS    (MAX_IDS),
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_PPB    (MAX_PPB)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .page_id_i   (s_axis_tdata_i),
    .hold_i      (!out_free),
    .ppb_i       (ppb_eff),
    .blocks_nz_o (blocks_nz),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result word register; the core runs the next command meanwhile and
  // parks its result until this register frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.id_space_length, out_q.free_total, out_q.live_total,
                            out_q.blocks_reclaimed, out_q.phys_slot, out_q.new_id};

endmodule

// File: tb/page_allocator_with_compaction_test.sv
// Self-checking bench for the page allocator: predictor, result scoreboard and stream drivers.
module page_allocator_with_compaction_test
  import pgalloc_pkg::*;
();

  localparam int NumIds    = 256;
  localparam int NumBlocks = 16;
  localparam int NumPpb    = 16;

  // Allocator model plus the queue of words still owed by the block.
  class alloc_scoreboard;
    logic [4:0] ppb_reg;
    bit         id_live[NumIds];
    int         id_slot[NumIds];
    int         table_len, live_cnt, stack_len, blocks_cnt;
    int         stack_slot[NumBlocks*NumPpb];
    res_t       pending[$];
    int         mismatches;

    function void clear();
      for (int i = 0; i < NumIds; i++) begin
        id_live[i] = 0;
        id_slot[i] = 0;
      end
      table_len = 0; live_cnt = 0; stack_len = 0; blocks_cnt = 0;
    endfunction

    function void reset_state();
      ppb_reg = PpbReset;
      clear();
      pending.delete();
      mismatches = 0;
    endfunction

    // Writes are dropped while any block is carved.
    function void write_ppb(logic [4:0] v);
      if (blocks_cnt == 0) ppb_reg = v;
    endfunction

    function int geom();
      if (ppb_reg == 0) return 1;
      if (ppb_reg > NumPpb) return NumPpb;
      return ppb_reg;
    endfunction

    function void push(int s);
      if (stack_len < NumBlocks*NumPpb) begin
        stack_slot[stack_len] = s;
        stack_len++;
      end
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] pid);
      res_t r;
      int   p, rank, kept;
      r = '0;
      p = geom();
      r.status = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          if (table_len >= NumIds) r.status = ST_FULL;
          else if (stack_len == 0 && blocks_cnt >= NumBlocks) r.status = ST_EXHAUSTED;
          else begin
            if (stack_len == 0) begin
              for (int i = 0; i < p; i++) push(blocks_cnt*p + i);
              blocks_cnt++;
            end
            stack_len--;
            r.phys_slot = 8'(stack_slot[stack_len]);
            r.new_id = 8'(table_len);
            id_live[table_len] = 1;
            id_slot[table_len] = stack_slot[stack_len];
            table_len++;
            live_cnt++;
          end
        end
        CMD_FREE: begin
          if (pid >= table_len) r.status = ST_RANGE;
          else if (!id_live[pid]) r.status = ST_DOUBLE;
          else begin
            push(id_slot[pid]);
            id_live[pid] = 0;
            id_slot[pid] = 0;
            live_cnt--;
            while (table_len > 0 && !id_live[table_len-1]) table_len--;
          end
        end
        CMD_COMPACT: begin
          if (blocks_cnt != 0) begin
            rank = 0;
            for (int i = 0; i < table_len; i++)
              if (id_live[i]) begin
                id_slot[i] = rank;
                rank++;
              end
            kept = (rank + p - 1) / p;
            if (kept > blocks_cnt) kept = blocks_cnt;
            r.blocks_reclaimed = 5'(blocks_cnt - kept);
            blocks_cnt = kept;
            stack_len = 0;
            for (int s = rank; s < kept*p; s++) push(s);
          end
        end
        default: begin
          r.blocks_reclaimed = 5'(blocks_cnt);
          clear();
        end
      endcase
      r.live_total = 9'(live_cnt);
      r.free_total = 9'(stack_len);
      r.id_space_length = 9'(table_len);
      pending = {pending, r};
    endfunction

    function void check_word(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [47:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  alloc_scoreboard board = new();
  bit   sink_hold = 0;     // long receiver stall
  bit   sink_eager = 0;    // no receiver idling
  int   accepted = 0;

  always #5 clk_i = ~clk_i;

  page_allocator_with_compaction DUT (.*);

  // Receiver: random backpressure per word, checks on accepted words.
  initial begin
    int gap;
    board.reset_state();
    forever begin
      @(negedge clk_i);
      gap = sink_eager ? 0 : $urandom_range(0, 19);
      if (gap != 0 || sink_hold) begin
        m_axis_tready_i <= 0;
        repeat (gap) @(negedge clk_i);
        while (sink_hold) @(negedge clk_i);
      end
      m_axis_tready_i <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_word(res_t'({m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
          m_axis_tdata_o[20:16], m_axis_tdata_o[29:21], m_axis_tdata_o[38:30],
          m_axis_tdata_o[47:39]}));
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] pid, bit idle);
    @(negedge clk_i);
    if (idle) repeat ($urandom_range(0, 19)) @(negedge clk_i);
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= pid;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_command(cmd, pid);
    accepted++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 0;
  endtask

  // Drain, then let the slowest compact finish before touching config.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [4:0] v);
    cfg_valid_i <= 1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_ppb(v);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Mostly allocs and valid frees with a few compacts; bias by phase.
  task automatic random_traffic(int n, int alloc_pct);
    int k;
    logic [7:0] pid;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (board.table_len > 0 && $urandom_range(0, 9) != 0)
        pid = 8'($urandom_range(0, board.table_len - 1));
      else
        pid = 8'($urandom);
      if (k < alloc_pct) send(CMD_ALLOC, pid, $urandom_range(0, 3) != 0);
      else if (k < 94) send(CMD_FREE, pid, $urandom_range(0, 3) != 0);
      else if (k < 99) send(CMD_COMPACT, pid, $urandom_range(0, 3) != 0);
      else send(CMD_RELEASE, pid, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    logic [4:0] geoms[6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd7, 5'd3};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: empty table, bad ids, compaction of nothing, default geometry.
    send(CMD_FREE, 8'd0, 0);
    send(CMD_FREE, 8'hff, 0);
    send(CMD_COMPACT, 8'h00, 0);
    send(CMD_RELEASE, 8'h00, 0);
    for (int i = 0; i < 6; i++) send(CMD_ALLOC, 8'h00, 0);
    send(CMD_FREE, 8'd1, 0);
    send(CMD_FREE, 8'd1, 0);       // already free
    send(CMD_FREE, 8'd5, 0);       // trims tail
    send(CMD_FREE, 8'd9, 0);       // beyond table
    drain();
    write_cfg(5'd9);               // locked: blocks held
    send(CMD_COMPACT, 8'h00, 0);
    send(CMD_RELEASE, 8'h00, 0);
    drain();

    // Geometry sweep, including 0 and out-of-range values.
    foreach (geoms[g]) begin
      write_cfg(geoms[g]);
      if (g == 1) begin
        // one page per block: exhaust the pool quickly
        for (int i = 0; i < 18; i++) send(CMD_ALLOC, 8'h00, 0);
      end
      random_traffic(120, 60);
      send(CMD_COMPACT, 8'h00, 0);
      send(CMD_RELEASE, 8'h00, 0);
      drain();
    end

    // Fill the id table to its limit with the largest geometry.
    write_cfg(5'd16);
    sink_eager = 1;
    for (int i = 0; i < 258; i++) send(CMD_ALLOC, 8'h00, 0);
    send(CMD_FREE, 8'd255, 0);
    send(CMD_FREE, 8'd128, 0);
    send(CMD_COMPACT, 8'h00, 0);
    sink_eager = 0;

    // Receiver stalls long while the sender keeps offering.
    fork
      begin
        sink_hold = 1;
        repeat (400) @(negedge clk_i);
        sink_hold = 0;
      end
      random_traffic(30, 40);
    join
    random_traffic(300, 45);
    drain();              // sender pause until all words are back
    write_cfg(5'd1);      // locked while any block is held
    random_traffic(200, 50);
    send(CMD_RELEASE, 8'h00, 0);
    drain();
    write_cfg(5'd5);
    random_traffic(200, 55);

    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
